@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the trie block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MXT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a result in the next cycle.
`define MXT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

@@ rtl/core/mxt_pkg.sv @@
// ---------------------------------------------------------------------------
// mxt_pkg
// Constants and types shared by the max-XOR trie block.
// ---------------------------------------------------------------------------
package mxt_pkg;

  localparam int KEY_BITS   = 32;
  localparam int POOL_NODES = 4096;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LVL_W      = $clog2(KEY_BITS + 1);
  localparam int FULL_LIMIT = POOL_NODES - KEY_BITS;

  // one trie node: child indices, zero means no child
  typedef struct packed {
    logic [NODE_W-1:0] c1;
    logic [NODE_W-1:0] c0;
  } node_t;

  // control handed to every bit cell of the chain
  typedef struct packed {
    logic load;
    logic shift_key;
    logic shift_acc;
  } cell_ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_INS_RD  = 6'b000010,
    ST_INS_CHK = 6'b000100,
    ST_INS_NEW = 6'b001000,
    ST_QRY_RD  = 6'b010000,
    ST_QRY_CHK = 6'b100000
  } state_t;

endpackage

@@ rtl/core/mxt_bit_cell.sv @@
// ---------------------------------------------------------------------------
// mxt_bit_cell
// One bit of the key and XOR accumulator chain; hands bits to its neighbor.
// ---------------------------------------------------------------------------
module mxt_bit_cell
  import mxt_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      load_key,
  input  logic      key_in,
  input  logic      acc_in,
  output logic      key_q,
  output logic      acc_q
);

  logic key_r;
  logic acc_r;

  // load a fresh beat, else rotate key and shift accumulator
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= load_key;
      acc_r <= 1'b0;
    end else begin
      if (ctl.shift_key) begin
        key_r <= key_in;
      end
      if (ctl.shift_acc) begin
        acc_r <= acc_in;
      end
    end
  end

  assign key_q = key_r;
  assign acc_q = acc_r;

endmodule

@@ rtl/core/max_xor_trie_stream.sv @@
// ---------------------------------------------------------------------------
// max_xor_trie_stream
// Flow: the insert walk reads and checks a node per level along the stored
//   path, then allocates and writes in ST_INS_NEW once the key leaves it;
//   the query walk then reads and checks per level, and the result register
//   follows. The insert walk is skipped when the pool is full. One item at
//   a time; the next start is taken at the edge that ends the result beat.
// Reset: synchronous active-low; trie emptied, running maximum zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module max_xor_trie_stream
  import mxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [31:0] out_best_xor,
  output logic [31:0] out_running_max,
  output logic        out_pool_full
);

  state_t            state_r, state_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  node_t             root_r, root_nxt;
  logic              full_r, full_nxt;
  logic [31:0]       max_r, max_nxt;
  logic              ovld_r, ovld_nxt;
  logic [31:0]       obest_r, obest_nxt;

  node_t             mem [POOL_NODES];
  node_t             rdata_r;
  logic              we;
  node_t             wdata;

  cell_ctl_t         ctl;
  logic [KEY_BITS-1:0] key_v;
  logic [KEY_BITS-1:0] acc_v;
  logic              acc_bit;
  logic              kbit;
  node_t             node_q;
  logic [NODE_W-1:0] want_c, other_c;
  logic [31:0]       best_v;

  // cell chain: key rotates, accumulator shifts in at the bottom
  for (genvar i = 0; i < KEY_BITS; i++) begin : g_cell
    mxt_bit_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_key (in_value[i]),
      .key_in   ((i == 0) ? key_v[KEY_BITS-1] : key_v[(i == 0) ? 0 : i-1]),
      .acc_in   ((i == 0) ? acc_bit : acc_v[(i == 0) ? 0 : i-1]),
      .key_q    (key_v[i]),
      .acc_q    (acc_v[i])
    );
  end

  assign kbit   = key_v[KEY_BITS-1];
  assign node_q = (cur_r == '0) ? root_r : rdata_r;
  assign busy   = (state_r != ST_IDLE);

  // node memory: single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[cur_r] <= wdata;
    end else if (state_r == ST_INS_RD || state_r == ST_QRY_RD) begin
      rdata_r <= mem[cur_r];
    end
  end

  // walk sequencer
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    cur_nxt       = cur_r;
    free_nxt      = free_r;
    root_nxt      = root_r;
    full_nxt      = full_r;
    max_nxt       = max_r;
    ovld_nxt      = 1'b0;
    obest_nxt     = obest_r;
    ctl           = '0;
    acc_bit       = 1'b0;
    we            = 1'b0;
    wdata         = node_q;
    want_c        = kbit ? node_q.c0 : node_q.c1;
    other_c       = kbit ? node_q.c1 : node_q.c0;
    best_v        = 32'(acc_v);

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          lvl_nxt  = LVL_W'(KEY_BITS);
          cur_nxt  = '0;
          full_nxt = (free_r > FREE_W'(FULL_LIMIT));
          state_nxt = full_nxt ? ST_QRY_RD : ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        ctl.shift_key = 1'b1;
        lvl_nxt       = lvl_r - 1'b1;
        if ((kbit ? node_q.c1 : node_q.c0) != '0) begin
          cur_nxt   = kbit ? node_q.c1 : node_q.c0;
          state_nxt = ST_INS_RD;
        end else begin
          // allocate the missing child and link it
          if (kbit) begin
            wdata.c1 = free_r[NODE_W-1:0];
          end else begin
            wdata.c0 = free_r[NODE_W-1:0];
          end
          if (cur_r == '0) begin
            root_nxt = wdata;
          end else begin
            we = 1'b1;
          end
          cur_nxt   = free_r[NODE_W-1:0];
          free_nxt  = free_r + 1'b1;
          state_nxt = ST_INS_NEW;
        end
        if (lvl_nxt == '0) begin
          cur_nxt   = '0;
          state_nxt = ST_QRY_RD;
        end
      end
      ST_INS_NEW: begin
        // fresh node: write it with its single new child
        ctl.shift_key = 1'b1;
        lvl_nxt       = lvl_r - 1'b1;
        we            = 1'b1;
        wdata         = '0;
        if (kbit) begin
          wdata.c1 = free_r[NODE_W-1:0];
        end else begin
          wdata.c0 = free_r[NODE_W-1:0];
        end
        cur_nxt  = free_r[NODE_W-1:0];
        free_nxt = free_r + 1'b1;
        if (lvl_nxt == '0) begin
          cur_nxt   = '0;
          state_nxt = ST_QRY_RD;
        end
      end
      ST_QRY_RD: begin
        state_nxt = ST_QRY_CHK;
      end
      ST_QRY_CHK: begin
        ctl.shift_key = 1'b1;
        ctl.shift_acc = 1'b1;
        lvl_nxt       = lvl_r - 1'b1;
        state_nxt     = ST_QRY_RD;
        if (want_c != '0) begin
          acc_bit = 1'b1;
          cur_nxt = want_c;
        end else begin
          cur_nxt = other_c;
        end
        best_v = 32'({acc_v[KEY_BITS-2:0], acc_bit});
        if (want_c == '0 && other_c == '0) begin
          // empty trie: drop the walk with a zero result
          ctl.shift_acc = 1'b0;
          best_v        = 32'(acc_v);
          lvl_nxt       = '0;
        end
        if (lvl_nxt == '0) begin
          obest_nxt = best_v;
          if (best_v > max_r) begin
            max_nxt = best_v;
          end
          ovld_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      free_r  <= FREE_W'(1);
      root_r  <= '0;
      max_r   <= '0;
      ovld_r  <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      free_r  <= free_nxt;
      root_r  <= root_nxt;
      max_r   <= max_nxt;
      ovld_r  <= ovld_nxt;
      full_r  <= full_nxt;
    end
  end

  // walk payload
  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    cur_r   <= cur_nxt;
    obest_r <= obest_nxt;
  end

  assign out_valid       = ovld_r;
  assign out_best_xor    = obest_r;
  assign out_running_max = max_r;
  assign out_pool_full   = full_r;

  `MXT_ASSERT(a_free_bound, free_r <= FREE_W'(POOL_NODES), "node pool overrun")
  `MXT_ASSERT(a_max_cover, !out_valid || out_running_max >= out_best_xor, "max below result")
  `MXT_ASSERT_NEXT(a_free_mono, 1'b1, free_r >= $past(free_r), "free pointer went back")
  `MXT_ASSERT_NEXT(a_full_hold, state_r == ST_INS_CHK || state_r == ST_INS_NEW, !full_r, "insert while full")

endmodule

@@ bench/mxt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mxt_checker
// Watches the command and result beats of the max-XOR trie block. Each
// accepted command is run through a trie predictor, and each result beat is
// compared with the oldest expectation.
// ----------------------------------------------------------------------------
module mxt_checker
  import mxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic [31:0] out_best_xor,
  input  logic [31:0] out_running_max,
  input  logic        out_pool_full,
  output int          fail_count,
  output int          pending,
  output int          full_seen,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] best_xor;
    logic [31:0] running_max;
    logic        pool_full;
  } xor_result_t;

  logic [NODE_W-1:0] kid0 [POOL_NODES];
  logic [NODE_W-1:0] kid1 [POOL_NODES];
  int                next_node;
  logic [31:0]       peak_xor;
  xor_result_t       xor_expected_q[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    full_seen    = 0;
    results_seen = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, want %h (t=%0t)", what, got, want, $time);
    fail_count++;
  endtask

  // Insert the key whole or not at all, then walk for the opposite bits
  task automatic trie_search(input logic [31:0] key, output xor_result_t res);
    int                cur;
    logic [NODE_W-1:0] nx;
    logic              want;
    logic [31:0]       acc;
    res.pool_full = (POOL_NODES - next_node) < KEY_BITS;
    if (!res.pool_full) begin
      cur = 0;
      for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
        nx = key[lvl] ? kid1[cur] : kid0[cur];
        if (nx == 0) begin
          nx = next_node[NODE_W-1:0];
          kid0[next_node] = '0;
          kid1[next_node] = '0;
          next_node++;
          if (key[lvl]) kid1[cur] = nx;
          else kid0[cur] = nx;
        end
        cur = nx;
      end
    end
    cur = 0;
    acc = '0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      want = ~key[lvl];
      nx = want ? kid1[cur] : kid0[cur];
      if (nx != 0) begin
        acc[lvl] = 1'b1;
        cur = nx;
      end else begin
        nx = want ? kid0[cur] : kid1[cur];
        if (nx == 0) break;
        cur = nx;
      end
    end
    if (acc > peak_xor) peak_xor = acc;
    res.best_xor    = acc;
    res.running_max = peak_xor;
  endtask

  // Predict on each accepted command, compare on each result beat
  always @(posedge clk) begin
    xor_result_t exp_r;
    if (!rst_n) begin
      kid0[0]   = '0;
      kid1[0]   = '0;
      next_node = 1;
      peak_xor  = '0;
      xor_expected_q.delete();
    end else begin
      if (out_valid) begin
        results_seen++;
        if (out_pool_full) full_seen++;
        if (xor_expected_q.size() == 0) begin
          report("unexpected beat", out_best_xor, 32'h0);
        end else begin
          exp_r = xor_expected_q.pop_front();
          if (out_best_xor !== exp_r.best_xor)
            report("best_xor", out_best_xor, exp_r.best_xor);
          if (out_running_max !== exp_r.running_max)
            report("running_max", out_running_max, exp_r.running_max);
          if (out_pool_full !== exp_r.pool_full)
            report("pool_full", {31'b0, out_pool_full}, {31'b0, exp_r.pool_full});
        end
      end
      if (start && !busy) begin
        trie_search(in_value, exp_r);
        xor_expected_q.push_back(exp_r);
      end
    end
    pending = xor_expected_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives key beats into the max-XOR trie block in random bursts, from
// directed corner keys through keys sharing prefixes until the node pool
// fills, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_KEYS = 1380;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_value;
  logic        out_valid;
  logic [31:0] out_best_xor;
  logic [31:0] out_running_max;
  logic        out_pool_full;
  int          fail_count;
  int          pending;
  int          full_seen;
  int          results_seen;
  int          cycle_count;
  int          keys_sent;
  logic [31:0] sent_keys[$];

  max_xor_trie_stream uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value(in_value),
    .out_valid(out_valid), .out_best_xor(out_best_xor),
    .out_running_max(out_running_max), .out_pool_full(out_pool_full)
  );

  mxt_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value(in_value),
    .out_valid(out_valid), .out_best_xor(out_best_xor),
    .out_running_max(out_running_max), .out_pool_full(out_pool_full),
    .fail_count(fail_count), .pending(pending), .full_seen(full_seen),
    .results_seen(results_seen)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[max_xor_trie_stream] ERROR");
      $finish;
    end
  end

  // Hold one key beat until it is taken; start stays high inside a burst
  task automatic send_key(input logic [31:0] key);
    start    = 1'b1;
    in_value = key;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent_keys.push_back(key);
    keys_sent++;
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      start    = 1'b0;
      in_value = $urandom();
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  // Mostly neighbors of earlier keys, so prefixes are shared and the pool lasts
  function automatic logic [31:0] pick_key();
    logic [31:0] base;
    case ($urandom_range(0, 9))
      0, 1, 2: pick_key = $urandom();
      3:       pick_key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      default: begin
        base = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        pick_key = base ^ ($urandom() >> $urandom_range(20, 31));
      end
    endcase
  endfunction

  initial begin
    start     = 1'b0;
    in_value  = '0;
    rst_n     = 1'b0;
    keys_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (3) @(negedge clk);

    // Corner keys: extremes, a repeat, walking ones, alternating patterns
    send_key(32'h0000_0000);
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'h7FFF_FFFF);
    send_key(32'hFFFF_FFFE);
    for (int b = 0; b < 32; b += 3) send_key(32'h1 << b);
    start = 1'b0;
    repeat (5) @(negedge clk);

    // Random bursts; the pool fills along the way, later keys query only
    for (int k = 0; k < RANDOM_KEYS; k++) begin
      send_key(pick_key());
      maybe_gap();
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("sent %0d keys, checked %0d results, %0d with the pool full",
             keys_sent, results_seen, full_seen);
    if (fail_count == 0) begin
      $display("[max_xor_trie_stream] OK");
    end else begin
      $display("[max_xor_trie_stream] ERROR");
    end
    $finish;
  end

endmodule

@@ max_xor_trie_stream.f @@
+incdir+rtl/core
rtl/core/mxt_pkg.sv
rtl/core/mxt_bit_cell.sv
rtl/core/max_xor_trie_stream.sv
bench/mxt_checker.sv
bench/tb_top.sv
